/* src/sbt_pkg.sv */
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and constants of the source byte tokenizer
// Token codes, character codes, keyword table and the queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sbt_pkg;

  // Saturating counter widths
  localparam int LINE_BITS   = 16;
  localparam int OFFSET_BITS = 24;
  localparam int LENGTH_BITS = 16;

  // Result field widths
  localparam int LINE_W   = 16;
  localparam int OFFSET_W = 24;
  localparam int LENGTH_W = 16;

  // Identifier prefix: first six characters, character i in byte lane i
  localparam int PREFIX_CHARS = 6;

  // Token queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [4:0] {
    TK_EOF      = 5'd0,
    TK_ASSIGN   = 5'd1,
    TK_COMMA    = 5'd2,
    TK_LPAREN   = 5'd3,
    TK_RPAREN   = 5'd4,
    TK_LBRACKET = 5'd5,
    TK_RBRACKET = 5'd6,
    TK_IDENT    = 5'd7,
    TK_AND      = 5'd8,
    TK_BOTH     = 5'd9,
    TK_DO       = 5'd10,
    TK_END      = 5'd11,
    TK_FALSE    = 5'd12,
    TK_INTENT   = 5'd13,
    TK_NOT      = 5'd14,
    TK_OR       = 5'd15,
    TK_TRUE     = 5'd16,
    TK_WHEN     = 5'd17
  } tok_kind_e;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_IDENT   = 2'd1,
    MODE_COMMENT = 2'd2
  } scan_mode_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_US    = 8'h5f;

  // Keywords, zero padded, first character in the low byte
  localparam int KW_COUNT = 10;
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h0000_0064_6e61,  // and
    48'h0000_6874_6f62,  // both
    48'h0000_0000_6f64,  // do
    48'h0000_0064_6e65,  // end
    48'h0065_736c_6166,  // false
    48'h746e_6574_6e69,  // intent
    48'h0000_0074_6f6e,  // not
    48'h0000_0000_726f,  // or
    48'h0000_6575_7274,  // true
    48'h0000_6e65_6877   // when
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd4, 3'd2, 3'd3, 3'd5, 3'd6, 3'd3, 3'd2, 3'd4, 3'd4
  };
  localparam tok_kind_e KW_KIND [KW_COUNT] = '{
    TK_AND, TK_BOTH, TK_DO, TK_END, TK_FALSE,
    TK_INTENT, TK_NOT, TK_OR, TK_TRUE, TK_WHEN
  };

  // One token on its way from front to back
  typedef struct packed {
    logic                is_ident;   // kind comes from the keyword lookup
    tok_kind_e           kind;       // kind of a non-identifier token
    logic [47:0]         prefix;
    logic                short_len;  // full length is at most six
    logic [2:0]          len3;       // low bits of the full length
    logic [LINE_W-1:0]   line;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic                last;
  } sbt_entry_t;

  // Up to two tokens pushed per accepted byte; valid1 implies valid0
  typedef struct packed {
    logic       valid0;
    logic       valid1;
    sbt_entry_t entry0;
    sbt_entry_t entry1;
  } sbt_push_t;

  function automatic tok_kind_e kw_lookup(logic [47:0] prefix, logic short_len,
                                          logic [2:0] len3);
    tok_kind_e kind;
    kind = TK_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (short_len && len3 == KW_LEN[k] && prefix == KW_TEXT[k]) begin
        kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

  function automatic logic [LINE_W-1:0] line_field(logic [LINE_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[LINE_W-1:0];
  endfunction

  function automatic logic [OFFSET_W-1:0] offset_field(logic [OFFSET_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[OFFSET_W-1:0];
  endfunction

  function automatic logic [LENGTH_W-1:0] length_field(logic [LENGTH_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[LENGTH_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/sbt_front.sv */
// ----------------------------------------------------------------------------
// sbt_front: scanner front end
// Holds the scan state, classifies each accepted byte and pushes its tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        char_byte_i,
  output sbt_pkg::sbt_push_t     push_o
);
  import sbt_pkg::*;

  scan_mode_e                    mode_q, mode_d;
  logic                          pend_q, pend_d;
  logic [LINE_BITS-1:0]          line_q, line_d;
  logic [OFFSET_BITS-1:0]        pos_q, pos_d;
  logic [PREFIX_CHARS-1:0][7:0]  prefix_q, prefix_d;
  logic [LENGTH_BITS-1:0]        len_q, len_d;
  logic [OFFSET_BITS-1:0]        begin_q, begin_d;

  logic       is_alpha, is_num, id_start, id_char;
  logic       id_emit, pun_emit;
  tok_kind_e  pun_kind;
  sbt_entry_t id_entry, pun_entry;

  always_comb begin
    is_alpha = char_byte_i inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    is_num   = char_byte_i inside {[8'h30:8'h39]};
    id_start = is_alpha || (char_byte_i == CH_US);
    id_char  = id_start || is_num;
  end

  // Next scan state and the tokens this byte causes
  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    line_d   = line_q;
    pos_d    = pos_q;
    prefix_d = prefix_q;
    len_d    = len_q;
    begin_d  = begin_q;
    id_emit  = 1'b0;
    pun_emit = 1'b0;
    pun_kind = TK_EOF;

    if (char_byte_i == CH_NUL) begin
      // End of source: flush identifier, emit eof, return to reset state
      id_emit  = (mode_q == MODE_IDENT);
      pun_emit = 1'b1;
      pun_kind = TK_EOF;
      mode_d   = MODE_NORMAL;
      pend_d   = 1'b0;
      line_d   = LINE_BITS'(1);
      pos_d    = '0;
      prefix_d = '0;
      len_d    = '0;
      begin_d  = '0;
    end else begin
      if (mode_q == MODE_COMMENT) begin
        if (char_byte_i == CH_NL) begin
          mode_d = MODE_NORMAL;
          if (line_q != '1) line_d = line_q + LINE_BITS'(1);
        end
      end else if (mode_q == MODE_IDENT && id_char) begin
        for (int i = 0; i < PREFIX_CHARS; i++) begin
          if (len_q == LENGTH_BITS'(i)) prefix_d[i] = char_byte_i;
        end
        if (len_q != '1) len_d = len_q + LENGTH_BITS'(1);
      end else begin
        id_emit = (mode_q == MODE_IDENT);
        mode_d  = MODE_NORMAL;
        if (pend_q && char_byte_i == CH_EQ) begin
          pend_d   = 1'b0;
          pun_emit = 1'b1;
          pun_kind = TK_ASSIGN;
        end else begin
          pend_d = 1'b0;
          case (char_byte_i)
            CH_NL: begin
              if (line_q != '1) line_d = line_q + LINE_BITS'(1);
            end
            CH_HASH:  mode_d = MODE_COMMENT;
            CH_LT:    pend_d = 1'b1;
            CH_COMMA: begin
              pun_emit = 1'b1;
              pun_kind = TK_COMMA;
            end
            CH_LPAR: begin
              pun_emit = 1'b1;
              pun_kind = TK_LPAREN;
            end
            CH_RPAR: begin
              pun_emit = 1'b1;
              pun_kind = TK_RPAREN;
            end
            CH_LBRK: begin
              pun_emit = 1'b1;
              pun_kind = TK_LBRACKET;
            end
            CH_RBRK: begin
              pun_emit = 1'b1;
              pun_kind = TK_RBRACKET;
            end
            default: begin
              if (id_start) begin
                mode_d      = MODE_IDENT;
                begin_d     = pos_q;
                len_d       = LENGTH_BITS'(1);
                prefix_d    = '0;
                prefix_d[0] = char_byte_i;
              end
            end
          endcase
        end
      end
      if (pos_q != '1) pos_d = pos_q + OFFSET_BITS'(1);
    end
  end

  // Token entries; every token of a byte carries the line before any newline
  always_comb begin
    id_entry           = '0;
    id_entry.is_ident  = 1'b1;
    id_entry.kind      = TK_IDENT;
    id_entry.prefix    = prefix_q;
    id_entry.short_len = (len_q < LENGTH_BITS'(PREFIX_CHARS + 1));
    id_entry.len3      = len_q[2:0];
    id_entry.line      = line_field(line_q);
    id_entry.offset    = offset_field(begin_q);
    id_entry.length    = length_field(len_q);
    id_entry.last      = !pun_emit;

    pun_entry          = '0;
    pun_entry.kind     = pun_kind;
    pun_entry.line     = line_field(line_q);
    pun_entry.last     = 1'b1;

    push_o = '0;
    if (id_emit) begin
      push_o.valid0 = accept_i;
      push_o.entry0 = id_entry;
      push_o.valid1 = accept_i && pun_emit;
      push_o.entry1 = pun_entry;
    end else begin
      push_o.valid0 = accept_i && pun_emit;
      push_o.entry0 = pun_entry;
      push_o.entry1 = pun_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NORMAL;
      pend_q   <= 1'b0;
      line_q   <= LINE_BITS'(1);
      pos_q    <= '0;
      prefix_q <= '0;
      len_q    <= '0;
      begin_q  <= '0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      line_q   <= line_d;
      pos_q    <= pos_d;
      prefix_q <= prefix_d;
      len_q    <= len_d;
      begin_q  <= begin_d;
    end
  end

endmodule

`default_nettype wire

/* src/sbt_queue.sv */
// ----------------------------------------------------------------------------
// sbt_queue: token queue
// Small circular buffer, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sbt_pkg::sbt_push_t push_i,
  input  wire logic               pop_i,
  output sbt_pkg::sbt_entry_t     head_o,
  output logic                    not_empty_o,
  output logic                    full_o
);
  import sbt_pkg::*;

  sbt_entry_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr1;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr1     = wr_ptr_q + QPTR_W'(1);
    head_o      = mem_q[rd_ptr_q];
    not_empty_o = (cnt_q != '0);
    // Accept a byte only with room for both of its tokens
    full_o      = (cnt_q > QCNT_W'(QDEPTH - 2));

    wr_ptr_d = wr_ptr_q;
    if (push_i.valid1)      wr_ptr_d = wr_ptr_q + QPTR_W'(2);
    else if (push_i.valid0) wr_ptr_d = wr_ptr1;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_i.valid0) + QCNT_W'(push_i.valid1)
               - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid0) mem_q[wr_ptr_q] <= push_i.entry0;
    if (push_i.valid1) mem_q[wr_ptr1]  <= push_i.entry1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* src/sbt_back.sv */
// ----------------------------------------------------------------------------
// sbt_back: token back end
// Resolves keywords and holds the result register toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sbt_pkg::sbt_entry_t           head_i,
  input  wire logic                          not_empty_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [4:0]                         token_kind_o,
  output logic [sbt_pkg::LINE_W-1:0]         line_number_o,
  output logic [sbt_pkg::OFFSET_W-1:0]       ident_offset_o,
  output logic [sbt_pkg::LENGTH_W-1:0]       ident_length_o,
  output logic                               last_in_run_o
);
  import sbt_pkg::*;

  logic                valid_q, valid_d;
  tok_kind_e           kind_q, kind_d;
  logic [LINE_W-1:0]   line_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [LENGTH_W-1:0] length_q;
  logic                last_q;

  always_comb begin
    // Advance when the result register is empty or being taken
    pop_o   = not_empty_i && (!valid_q || !out_stall_i);
    valid_d = pop_o || (valid_q && out_stall_i);
    kind_d  = head_i.is_ident
              ? kw_lookup(head_i.prefix, head_i.short_len, head_i.len3)
              : head_i.kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= kind_d;
      line_q   <= head_i.line;
      offset_q <= head_i.offset;
      length_q <= head_i.length;
      last_q   <= head_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign token_kind_o   = kind_q;
  assign line_number_o  = line_q;
  assign ident_offset_o = offset_q;
  assign ident_length_o = length_q;
  assign last_in_run_o  = last_q;

endmodule

`default_nettype wire

/* src/source_byte_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// source_byte_tokenizer_core: streaming source tokenizer
// Turns a byte stream into tokens: punctuation, '<=', identifiers, keywords.
// ----------------------------------------------------------------------------
// The core takes one source byte per clock while in_stall is low and gives
// zero, one or two tokens for it. A byte's tokens are written into the token
// queue as the byte is taken and move from there into the result register,
// which drives the output. A byte that closes an identifier and is itself a
// token (a comma, parenthesis, bracket or end of source) gives the identifier
// first and then its own token. Input stall rises only when the four-entry
// token queue has fewer than two free slots, so with a consumer that never
// stalls the input runs at one byte per cycle. Byte zero ends the source: any
// open identifier is flushed, an eof token follows, and the scan state
// returns to its reset values. Identifiers are reported by start offset and
// length; the line, offset and length counters saturate. last_in_run marks
// the last token of each byte.
`default_nettype none

module source_byte_tokenizer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    char_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [4:0]                         token_kind_o,
  output logic [sbt_pkg::LINE_W-1:0]         line_number_o,
  output logic [sbt_pkg::OFFSET_W-1:0]       ident_offset_o,
  output logic [sbt_pkg::LENGTH_W-1:0]       ident_length_o,
  output logic                               last_in_run_o
);
  import sbt_pkg::*;

  sbt_push_t  push;
  sbt_entry_t head;
  logic       accept, pop, not_empty, full;

  // Take a request when the queue can absorb two tokens
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  sbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_byte_i (char_byte_i),
    .push_o      (push)
  );

  sbt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .full_o      (full)
  );

  sbt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .not_empty_i    (not_empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .line_number_o  (line_number_o),
    .ident_offset_o (ident_offset_o),
    .ident_length_o (ident_length_o),
    .last_in_run_o  (last_in_run_o)
  );

endmodule

`default_nettype wire
